### sv/pru_pkg.sv
// Package: shared types, codes and address mapping for the picture unit register port.
`timescale 1ns / 1ps
`default_nettype none
package pru_pkg;

    localparam int NT_BYTES_DEF = 2048;
    localparam int SPR_BYTES    = 256;
    localparam logic [23:0] DECAY_RESET = 24'd1789773;

    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_TICK      = 3'd2,
        OP_VBLANK    = 3'd3,
        OP_PRERENDER = 3'd4,
        OP_FLAGS     = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        CFG_MIRROR = 2'd0,
        CFG_EARLY  = 2'd1,
        CFG_PERIOD = 2'd2
    } t_cfg;

    typedef struct packed {
        logic [7:0]  ctrl;
        logic [7:0]  mask;
        logic [7:0]  status;
        logic [7:0]  sp;
        logic [15:0] cur;
        logic [15:0] tmp;
        logic [2:0]  fine_x;
        logic        w;
        logic [7:0]  rb;
        logic [7:0]  ob;
        logic [23:0] cd;
    } t_state;

    typedef struct packed {
        logic nt;
        logic pal;
        logic spr;
    } t_mem_we;

    function automatic logic [10:0] nt_index(input logic [15:0] a, input logic mv);
        nt_index = {(mv ? a[10] : a[11]), a[9:0]};
    endfunction

    function automatic logic [4:0] pal_index(input logic [15:0] a);
        pal_index = {(a[4] && (a[1:0] == 2'b00)) ? 1'b0 : a[4], a[3:0]};
    endfunction

endpackage
`default_nettype wire

### sv/pru_exec.sv
// Execute stage: register updates, read data and memory write enables for one item.
`timescale 1ns / 1ps
`default_nettype none
module pru_exec (
    input  wire  logic [2:0]     i_op,
    input  wire  logic [2:0]     i_reg,
    input  wire  logic [7:0]     i_data,
    input  wire  logic [7:0]     i_cyc,
    input  wire  logic           i_early,
    input  wire  logic [23:0]    i_period,
    input  wire  pru_pkg::t_state i_st,
    input  wire  logic [7:0]     i_nt_q,
    input  wire  logic [7:0]     i_pal_q,
    input  wire  logic [7:0]     i_spr_q,
    output pru_pkg::t_state      o_st,
    output pru_pkg::t_mem_we     o_we,
    output logic [7:0]           o_rd,
    output logic                 o_nmi
);
    import pru_pkg::*;

    logic [13:0] a14;
    logic        is_nt;
    logic        is_pal;
    logic [7:0]  pv;
    logic [15:0] step;
    logic [15:0] t1;

    always_comb begin
        o_st  = i_st;
        o_we  = '0;
        o_rd  = '0;
        o_nmi = 1'b0;
        t1    = '0;
        a14    = i_st.cur[13:0];
        is_nt  = (a14 >= 14'h2000) && (a14 <= 14'h3EFF);
        is_pal = (a14 >= 14'h3F00);
        pv     = (i_pal_q & (i_st.mask[0] ? 8'h30 : 8'h3F)) | (i_st.ob & 8'hC0);
        step   = i_st.ctrl[2] ? 16'd32 : 16'd1;
        case (i_op)
            OP_READ: begin
                case (i_reg)
                    REG_STATUS: begin
                        if (i_early) begin
                            o_rd = i_st.status | (i_st.ob & 8'h1F);
                        end else begin
                            o_st.ob = i_st.ob & 8'h1F;
                            o_st.cd = i_period;
                            o_rd    = i_st.status | (i_st.ob & 8'h1F);
                        end
                        o_st.status[7] = 1'b0;
                        o_st.w         = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        o_rd = i_spr_q & (i_early ? 8'hE1 : 8'hFF);
                        if (i_st.sp != 8'd0 && !i_st.sp[0]) begin
                            o_st.ob = 8'h00;
                            o_st.cd = i_period;
                        end
                    end
                    REG_DATA: begin
                        if (is_pal) begin
                            o_rd    = pv;
                            o_st.rb = i_nt_q;
                        end else begin
                            o_rd    = i_st.rb;
                            o_st.rb = is_nt ? i_nt_q : 8'h00;
                        end
                        o_st.cur = i_st.cur + step;
                        o_st.ob  = o_rd;
                        o_st.cd  = i_period;
                    end
                    default: o_rd = i_st.ob;
                endcase
            end
            OP_WRITE: begin
                case (i_reg)
                    REG_CTRL: begin
                        o_nmi     = i_st.status[7] && !i_st.ctrl[7] && i_data[7];
                        o_st.ctrl = i_data;
                        o_st.tmp  = (i_st.tmp & 16'hF3FF) | {4'b0, i_data[1:0], 10'b0};
                    end
                    REG_MASK:     o_st.mask = i_data;
                    REG_OAM_ADDR: o_st.sp = i_data;
                    REG_OAM_DATA: begin
                        o_we.spr = 1'b1;
                        o_st.sp  = i_st.sp + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!i_st.w) begin
                            o_st.fine_x = i_data[2:0];
                            o_st.tmp    = (i_st.tmp & 16'hFFE0) | {11'b0, i_data[7:3]};
                        end else begin
                            t1       = (i_st.tmp & 16'h8FFF) | {1'b0, i_data[2:0], 12'b0};
                            o_st.tmp = (t1 & 16'hFC1F) | {6'b0, i_data[7:3], 5'b0};
                        end
                        o_st.w = !i_st.w;
                    end
                    REG_ADDR: begin
                        if (!i_st.w) begin
                            o_st.tmp = (i_st.tmp & 16'h80FF) | {2'b0, i_data[5:0], 8'b0};
                        end else begin
                            o_st.tmp = {i_st.tmp[15:8], i_data};
                            o_st.cur = {i_st.tmp[15:8], i_data};
                        end
                        o_st.w = !i_st.w;
                    end
                    REG_DATA: begin
                        o_we.nt  = is_nt;
                        o_we.pal = is_pal;
                        o_st.cur = i_st.cur + step;
                    end
                    default: ;
                endcase
                o_st.ob = i_data;
                o_st.cd = i_period;
            end
            OP_TICK: begin
                if (i_st.ob != 8'h00) begin
                    if (i_st.cd <= {16'b0, i_cyc}) begin
                        o_st.cd = '0;
                        o_st.ob = 8'h00;
                    end else begin
                        o_st.cd = i_st.cd - {16'b0, i_cyc};
                    end
                end
            end
            OP_VBLANK: begin
                o_st.status[7] = 1'b1;
                o_nmi          = i_st.ctrl[7];
            end
            OP_PRERENDER: o_st.status = 8'h00;
            OP_FLAGS:     o_st.status = i_st.status | (i_data & 8'h60);
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### sv/picture_unit_register_port_top.sv
// Top level: picture unit register port with nametable, palette and sprite memories.
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per clock cycle when the output side keeps up. The nametable, palette and
// sprite memories (one read and one write port each, registered read) are addressed in the
// cycle an item is accepted. The item then waits in the execute stage, where
// registers update and memories are written; a same-entry write ahead of a read is forwarded.
// The result sits in an output register, so o_valid rises only after the execute stage fires.
// Memories are not cleared after reset; entries read before being written return anything.
module picture_unit_register_port_top #(
    parameter int NAMETABLE_BYTES = pru_pkg::NT_BYTES_DEF
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_cfg_we,
    input  wire  logic [1:0]  i_cfg_index,
    input  wire  logic [23:0] i_cfg_data,
    input  wire  logic        i_valid,
    output logic              o_ready,
    input  wire  logic [2:0]  i_opcode,
    input  wire  logic [2:0]  i_reg_index,
    input  wire  logic [7:0]  i_write_data,
    input  wire  logic [7:0]  i_tick_cycles,
    output logic              o_valid,
    input  wire  logic        i_ready,
    output logic [7:0]        o_read_data,
    output logic              o_nmi_pulse
);
    import pru_pkg::*;

    localparam int NT_AW = $clog2(NAMETABLE_BYTES);

    logic        r_mirror;
    logic        r_early;
    logic [23:0] r_period;

    t_state      r_st;
    t_state      n_st;
    t_mem_we     we;
    logic [7:0]  ex_rd;
    logic        ex_nmi;

    logic        r_s1_valid;
    logic [2:0]  r_s1_op;
    logic [2:0]  r_s1_reg;
    logic [7:0]  r_s1_data;
    logic [7:0]  r_s1_cyc;

    logic        r_o_valid;
    logic [7:0]  r_o_rd;
    logic        r_o_nmi;

    logic        s1_fire;
    logic        acc;
    logic [15:0] eff_cur;
    logic [7:0]  eff_sp;

    logic [NT_AW-1:0] ra_nt;
    logic [NT_AW-1:0] wa_nt;
    logic [4:0]       ra_pal;
    logic [4:0]       wa_pal;

    logic [7:0] nt_mem  [NAMETABLE_BYTES];
    logic [7:0] pal_mem [32];
    logic [7:0] spr_mem [SPR_BYTES];

    logic [7:0] r_nt_q;
    logic [7:0] r_pal_q;
    logic [7:0] r_spr_q;
    logic       r_nt_fwd;
    logic       r_pal_fwd;
    logic       r_spr_fwd;
    logic [7:0] r_fwd_data;
    logic [7:0] nt_q;
    logic [7:0] pal_q;
    logic [7:0] spr_q;

    assign s1_fire = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign acc     = i_valid && o_ready;

    assign eff_cur = s1_fire ? n_st.cur : r_st.cur;
    assign eff_sp  = s1_fire ? n_st.sp : r_st.sp;
    assign ra_nt   = NT_AW'(nt_index(eff_cur, r_mirror));
    assign wa_nt   = NT_AW'(nt_index(r_st.cur, r_mirror));
    assign ra_pal  = pal_index(eff_cur);
    assign wa_pal  = pal_index(r_st.cur);

    assign nt_q  = r_nt_fwd ? r_fwd_data : r_nt_q;
    assign pal_q = r_pal_fwd ? r_fwd_data : r_pal_q;
    assign spr_q = r_spr_fwd ? r_fwd_data : r_spr_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror <= 1'b0;
            r_early  <= 1'b0;
            r_period <= DECAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIRROR: r_mirror <= i_cfg_data[0];
                CFG_EARLY:  r_early  <= i_cfg_data[0];
                CFG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && we.nt) begin
            nt_mem[wa_nt] <= r_s1_data;
        end
        if (s1_fire && we.pal) begin
            pal_mem[wa_pal] <= r_s1_data;
        end
        if (s1_fire && we.spr) begin
            spr_mem[r_st.sp] <= r_s1_data;
        end
        if (acc) begin
            r_nt_q     <= nt_mem[ra_nt];
            r_pal_q    <= pal_mem[ra_pal];
            r_spr_q    <= spr_mem[eff_sp];
            r_nt_fwd   <= s1_fire && we.nt && (wa_nt == ra_nt);
            r_pal_fwd  <= s1_fire && we.pal && (wa_pal == ra_pal);
            r_spr_fwd  <= s1_fire && we.spr && (r_st.sp == eff_sp);
            r_fwd_data <= r_s1_data;
            r_s1_op    <= i_opcode;
            r_s1_reg   <= i_reg_index;
            r_s1_data  <= i_write_data;
            r_s1_cyc   <= i_tick_cycles;
        end
    end

    pru_exec u_exec (
        .i_op     (r_s1_op),
        .i_reg    (r_s1_reg),
        .i_data   (r_s1_data),
        .i_cyc    (r_s1_cyc),
        .i_early  (r_early),
        .i_period (r_period),
        .i_st     (r_st),
        .i_nt_q   (nt_q),
        .i_pal_q  (pal_q),
        .i_spr_q  (spr_q),
        .o_st     (n_st),
        .o_we     (we),
        .o_rd     (ex_rd),
        .o_nmi    (ex_nmi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_st <= n_st;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_o_rd  <= ex_rd;
            r_o_nmi <= ex_nmi;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_read_data = r_o_rd;
    assign o_nmi_pulse = r_o_nmi;

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while execute stage is stalled");

    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_op == OP_READ && r_s1_reg == REG_STATUS) |=> !r_st.status[7])
        else $error("status read left vblank flag set");

    a_idle_bus_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_op == OP_TICK && r_st.ob == 8'h00) |=> $stable(r_st.cd))
        else $error("decay countdown moved with open bus at zero");

endmodule
`default_nettype wire

### tb/sv/picture_unit_register_port_top_tb.sv
// Testbench: random and directed bus items against a predictor of the picture unit register port.
`timescale 1ns / 1ps
module picture_unit_register_port_top_tb;
    import pru_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 250;

    typedef struct {
        logic [2:0] op;
        logic [2:0] rg;
        logic [7:0] data;
        logic [7:0] cyc;
    } bus_item_t;

    typedef struct {
        logic [7:0] rd;
        logic       nmi;
    } bus_result_t;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [23:0] i_cfg_data = 0;
    logic        i_valid = 0;
    logic [2:0]  i_opcode = 0;
    logic [2:0]  i_reg_index = 0;
    logic [7:0]  i_write_data = 0;
    logic [7:0]  i_tick_cycles = 0;
    logic        i_ready = 0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic        o_nmi_pulse;

    picture_unit_register_port_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_reg_index(i_reg_index),
        .i_write_data(i_write_data), .i_tick_cycles(i_tick_cycles),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_read_data(o_read_data), .o_nmi_pulse(o_nmi_pulse)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    bus_item_t   pending_items[$];
    bus_result_t expected_results[$];
    int          errors = 0;
    int          received = 0;
    bit          idle_on = 1;

    // predicted block state
    logic [7:0]  p_ctrl, p_mask, p_stat, p_sp, p_rb, p_ob;
    logic [15:0] p_cur, p_tmp;
    logic [2:0]  p_fx;
    logic        p_w;
    logic [31:0] p_cd;
    logic        p_mv, p_early;
    logic [23:0] p_period;
    logic [7:0]  nt_mem[2048];
    logic [7:0]  pal_mem[32];
    logic [7:0]  spr_mem[256];
    bit          nt_ok[2048];
    bit          pal_ok[32];
    bit          spr_ok[256];

    function automatic int nt_slot(logic [15:0] a);
        int x, off;
        x = a & 16'h0FFF;
        if (p_mv)
            off = (x & 'h3FF) + ((x >= 'h400 && x < 'h800) ? 'h400 : 0) + ((x >= 'hC00) ? 'h400 : 0);
        else
            off = (x < 'h800) ? (x & 'h3FF) : ((x & 'h3FF) + 'h400);
        return off % 2048;
    endfunction

    function automatic int pal_slot(logic [15:0] a);
        int p;
        p = a & 'h1F;
        if ((p & 3) == 0 && (p & 'h10) != 0) p = p & 'h0F;
        return p;
    endfunction

    function automatic bit entry_written(logic [15:0] a);
        a = a & 16'h3FFF;
        if (a >= 16'h2000 && a <= 16'h3EFF) return nt_ok[nt_slot(a)];
        if (a >= 16'h3F00) return pal_ok[pal_slot(a)];
        return 1;
    endfunction

    function automatic logic [7:0] vram_load(logic [15:0] a);
        logic [7:0] m;
        a = a & 16'h3FFF;
        if (a >= 16'h2000 && a <= 16'h3EFF) return nt_mem[nt_slot(a)];
        if (a >= 16'h3F00) begin
            m = p_mask[0] ? 8'h30 : 8'h3F;
            return (pal_mem[pal_slot(a)] & m) | (p_ob & 8'hC0);
        end
        return 8'h00;
    endfunction

    task automatic vram_store(logic [15:0] a, logic [7:0] v);
        a = a & 16'h3FFF;
        if (a >= 16'h2000 && a <= 16'h3EFF) begin
            nt_mem[nt_slot(a)] = v;
            nt_ok[nt_slot(a)] = 1;
        end else if (a >= 16'h3F00) begin
            pal_mem[pal_slot(a)] = v;
            pal_ok[pal_slot(a)] = 1;
        end
    endtask

    task automatic latch_bus(logic [7:0] v);
        p_ob = v;
        p_cd = p_period;
    endtask

    task automatic step_address();
        p_cur = p_cur + (p_ctrl[2] ? 16'd32 : 16'd1);
    endtask

    task automatic predict_item(bus_item_t it, output bus_result_t r);
        r.rd = 0;
        r.nmi = 0;
        case (it.op)
            OP_READ: begin
                case (it.rg)
                    REG_STATUS: begin
                        if (p_early) begin
                            r.rd = p_stat | (p_ob & 8'h1F);
                        end else begin
                            latch_bus(p_ob & 8'h1F);
                            r.rd = p_stat | p_ob;
                        end
                        p_stat = p_stat & 8'h7F;
                        p_w = 0;
                    end
                    REG_OAM_DATA: begin
                        r.rd = spr_mem[p_sp] & (p_early ? 8'hE1 : 8'hFF);
                        if (p_sp != 0 && !p_sp[0]) latch_bus(8'h00);
                    end
                    REG_DATA: begin
                        if ((p_cur & 16'h3FFF) >= 16'h3F00) begin
                            r.rd = vram_load(p_cur);
                            p_rb = vram_load(p_cur - 16'h1000);
                        end else begin
                            r.rd = p_rb;
                            p_rb = vram_load(p_cur);
                        end
                        step_address();
                        latch_bus(r.rd);
                    end
                    default: r.rd = p_ob;
                endcase
            end
            OP_WRITE: begin
                case (it.rg)
                    REG_CTRL: begin
                        if (p_stat[7] && !p_ctrl[7] && it.data[7]) r.nmi = 1;
                        p_ctrl = it.data;
                        p_tmp = (p_tmp & 16'hF3FF) | (16'(it.data[1:0]) << 10);
                    end
                    REG_MASK: p_mask = it.data;
                    REG_OAM_ADDR: p_sp = it.data;
                    REG_OAM_DATA: begin
                        spr_mem[p_sp] = it.data;
                        spr_ok[p_sp] = 1;
                        p_sp = p_sp + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!p_w) begin
                            p_fx = it.data[2:0];
                            p_tmp = (p_tmp & 16'hFFE0) | 16'(it.data[7:3]);
                        end else begin
                            p_tmp = (p_tmp & 16'h8FFF) | (16'(it.data[2:0]) << 12);
                            p_tmp = (p_tmp & 16'hFC1F) | (16'(it.data & 8'hF8) << 2);
                        end
                        p_w = ~p_w;
                    end
                    REG_ADDR: begin
                        if (!p_w) begin
                            p_tmp = (p_tmp & 16'h80FF) | (16'(it.data[5:0]) << 8);
                        end else begin
                            p_tmp = {p_tmp[15:8], it.data};
                            p_cur = p_tmp;
                        end
                        p_w = ~p_w;
                    end
                    REG_DATA: begin
                        vram_store(p_cur, it.data);
                        step_address();
                    end
                    default: ;
                endcase
                latch_bus(it.data);
            end
            OP_TICK: begin
                if (p_ob != 0) begin
                    if (p_cd <= 32'(it.cyc)) begin
                        p_cd = 0;
                        p_ob = 0;
                    end else begin
                        p_cd = p_cd - 32'(it.cyc);
                    end
                end
            end
            OP_VBLANK: begin
                p_stat = p_stat | 8'h80;
                if (p_ctrl[7]) r.nmi = 1;
            end
            OP_PRERENDER: p_stat = 8'h00;
            OP_FLAGS: p_stat = p_stat | (it.data & 8'h60);
            default: ;
        endcase
    endtask

    // Queues one item; reads of memory entries never written turn into writes.
    task automatic queue_item(logic [2:0] op, logic [2:0] rg, logic [7:0] d, logic [7:0] c);
        bus_item_t   it;
        bus_result_t r;
        bit          ok;
        if (op == OP_READ && rg == REG_OAM_DATA && !spr_ok[p_sp]) op = OP_WRITE;
        if (op == OP_READ && rg == REG_DATA) begin
            if ((p_cur & 16'h3FFF) >= 16'h3F00)
                ok = entry_written(p_cur) && entry_written(p_cur - 16'h1000);
            else
                ok = entry_written(p_cur);
            if (!ok) op = OP_WRITE;
        end
        it.op = op;
        it.rg = rg;
        it.data = d;
        it.cyc = c;
        predict_item(it, r);
        pending_items.push_back(it);
        expected_results.push_back(r);
    endtask

    task automatic random_burst();
        int k, n;
        logic [7:0] hi, ptr;
        k = $urandom_range(0, 99);
        if (k < 30) begin
            queue_item(OP_READ, REG_STATUS, 0, 0);
            hi = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(8'h20, 8'h3F)) : 8'($urandom);
            queue_item(OP_WRITE, REG_ADDR, hi, 8'($urandom));
            queue_item(OP_WRITE, REG_ADDR, 8'($urandom), 8'($urandom));
            n = $urandom_range(1, 6);
            repeat (n) queue_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_DATA,
                                  8'($urandom), 8'($urandom));
        end else if (k < 45) begin
            ptr = 8'($urandom);
            n = $urandom_range(1, 5);
            queue_item(OP_WRITE, REG_OAM_ADDR, ptr, 0);
            repeat (n) queue_item(OP_WRITE, REG_OAM_DATA, 8'($urandom), 8'($urandom));
            queue_item(OP_WRITE, REG_OAM_ADDR, ptr, 0);
            repeat (n) queue_item(OP_READ, REG_OAM_DATA, 8'($urandom), 8'($urandom));
        end else if (k < 55) begin
            queue_item(OP_READ, REG_STATUS, 0, 0);
            queue_item(OP_WRITE, REG_SCROLL, 8'($urandom), 0);
            queue_item(OP_WRITE, REG_SCROLL, 8'($urandom), 0);
        end else if (k < 65) begin
            queue_item(OP_WRITE, $urandom_range(0, 1) ? REG_CTRL : REG_MASK,
                       8'($urandom), 8'($urandom));
        end else if (k < 80) begin
            queue_item(3'($urandom_range(OP_TICK, OP_FLAGS)), 3'($urandom),
                       8'($urandom), 8'($urandom));
        end else begin
            queue_item(3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_MIRROR: p_mv = val[0];
            CFG_EARLY:  p_early = val[0];
            CFG_PERIOD: p_period = val;
            default: ;
        endcase
    endtask

    // sender
    int gap_tx = 0;
    always @(posedge i_clk) begin
        bus_item_t it;
        logic      nv;
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!(i_valid && !o_ready)) begin
            nv = 0;
            if (gap_tx > 0) begin
                gap_tx--;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_opcode <= it.op;
                i_reg_index <= it.rg;
                i_write_data <= it.data;
                i_tick_cycles <= it.cyc;
                nv = 1;
                gap_tx = idle_on ? $urandom_range(0, 15) : 0;
            end
            i_valid <= nv;
        end
    end

    // receiver and checker
    int stall_rx = 0;
    int hold_rx = 0;
    bit held = 0;
    always @(posedge i_clk) begin
        bus_result_t e;
        logic        nr;
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                received++;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected item rd=%h nmi=%b", o_read_data, o_nmi_pulse);
                end else begin
                    e = expected_results.pop_front();
                    if (e.rd !== o_read_data || e.nmi !== o_nmi_pulse) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch item %0d: exp rd=%h nmi=%b got rd=%h nmi=%b",
                                     received, e.rd, e.nmi, o_read_data, o_nmi_pulse);
                    end
                end
                stall_rx = idle_on ? $urandom_range(0, 15) : 0;
                if (received == 400 && !held) begin
                    held = 1;
                    hold_rx = 400;
                end
            end
            nr = 1;
            if (hold_rx > 0) begin
                hold_rx--;
                nr = 0;
            end else if (stall_rx > 0) begin
                stall_rx--;
                nr = 0;
            end
            i_ready <= nr;
        end
    end

    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        p_ctrl = 0; p_mask = 0; p_stat = 0; p_sp = 0; p_rb = 0; p_ob = 0;
        p_cur = 0; p_tmp = 0; p_fx = 0; p_w = 0; p_cd = 0;
        p_mv = 0; p_early = 0; p_period = DECAY_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: register reads, events, nmi paths, unused opcodes, tick extremes
        for (int r = 0; r < 8; r++) queue_item(OP_READ, 3'(r), 0, 0);
        queue_item(OP_WRITE, REG_CTRL, 8'h80, 0);
        queue_item(OP_VBLANK, 0, 0, 0);
        queue_item(OP_WRITE, REG_CTRL, 8'h00, 0);
        queue_item(OP_WRITE, REG_CTRL, 8'hFF, 0);
        queue_item(OP_READ, REG_STATUS, 0, 0);
        queue_item(OP_FLAGS, 0, 8'hFF, 0);
        queue_item(OP_READ, REG_STATUS, 0, 0);
        queue_item(OP_PRERENDER, 0, 0, 0);
        queue_item(3'd6, 3'd7, 8'hFF, 8'hFF);
        queue_item(3'd7, 3'd0, 8'h00, 8'h00);
        queue_item(OP_WRITE, REG_MASK, 8'h01, 0);
        queue_item(OP_TICK, 0, 0, 8'h00);
        queue_item(OP_TICK, 0, 0, 8'hFF);
        queue_item(OP_WRITE, REG_CTRL, 8'h00, 0);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: begin write_reg(CFG_MIRROR, 1); write_reg(CFG_EARLY, 1);
                         write_reg(CFG_PERIOD, 1); end
                2: begin write_reg(CFG_MIRROR, 0); write_reg(CFG_EARLY, 0);
                         write_reg(CFG_PERIOD, 24'hFFFFFF); end
                3: begin write_reg(CFG_MIRROR, 1); write_reg(CFG_EARLY, 0);
                         write_reg(CFG_PERIOD, 24'($urandom_range(50, 600))); end
                4: begin write_reg(CFG_MIRROR, 0); write_reg(CFG_EARLY, 1);
                         write_reg(CFG_PERIOD, 24'($urandom_range(200, 2000))); end
                default: begin write_reg(CFG_MIRROR, 1); write_reg(CFG_EARLY, 1);
                         write_reg(CFG_PERIOD, DECAY_RESET); end
            endcase
            idle_on = (ph != 2);
            while (pending_items.size() < PHASE_ITEMS) random_burst();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### sim.f
sv/pru_pkg.sv
sv/pru_exec.sv
sv/picture_unit_register_port_top.sv
tb/sv/picture_unit_register_port_top_tb.sv
